/* sv/sst_pkg.sv */
// Package for the event-stream tokenizer: token and phase codes, token struct,
// known field name tables. Used by sse_stream_tokenizer; no dependencies.
package sst_pkg;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_COLON   = 3'd2;
  localparam logic [2:0] PH_FIRST   = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_COMMENT = 3'd5;

  localparam logic [2:0] FK_UNKNOWN = 3'd0;
  localparam logic [2:0] FK_DATA    = 3'd1;
  localparam logic [2:0] FK_EVENT   = 3'd2;
  localparam logic [2:0] FK_ID      = 3'd3;
  localparam logic [2:0] FK_RETRY   = 3'd4;

  localparam logic [3:0] TK_DATA_BYTE   = 4'd0;
  localparam logic [3:0] TK_TYPE_START  = 4'd1;
  localparam logic [3:0] TK_TYPE_BYTE   = 4'd2;
  localparam logic [3:0] TK_ID_BYTE     = 4'd3;
  localparam logic [3:0] TK_ID_COMMIT   = 4'd4;
  localparam logic [3:0] TK_ID_REJECT   = 4'd5;
  localparam logic [3:0] TK_RETRY_SET   = 4'd6;
  localparam logic [3:0] TK_RETRY_CLEAR = 4'd7;
  localparam logic [3:0] TK_DISPATCH    = 4'd8;
  localparam logic [3:0] TK_DISCARD     = 4'd9;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] CAND_ALL = 4'hF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] ms;
    logic        dflt;
  } tok_t;

  // names: 0 data, 1 event, 2 id, 3 retry
  function automatic logic [7:0] name_char(logic [1:0] idx, logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (idx)
      2'd0: begin
        case (pos)
          3'd0: c = "d";
          3'd1: c = "a";
          3'd2: c = "t";
          3'd3: c = "a";
          default: c = CH_NUL;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: c = "e";
          3'd1: c = "v";
          3'd2: c = "e";
          3'd3: c = "n";
          3'd4: c = "t";
          default: c = CH_NUL;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: c = "i";
          3'd1: c = "d";
          default: c = CH_NUL;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = "r";
          3'd1: c = "e";
          3'd2: c = "t";
          3'd3: c = "r";
          3'd4: c = "y";
          default: c = CH_NUL;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_len(logic [1:0] idx);
    logic [2:0] l;
    case (idx)
      2'd0: l = 3'd4;
      2'd1: l = 3'd5;
      2'd2: l = 3'd2;
      default: l = 3'd5;
    endcase
    return l;
  endfunction

endpackage

/* sv/sse_stream_tokenizer.sv */
// Event-stream tokenizer top level: line splitting, field name match, value tokens.
// Depends on sst_pkg.
// An accepted byte's token is registered in the output register, or in the skid entry if the output is held.
// Throughput: one byte per cycle while the skid entry is empty; all parsing state updates in the accepting cycle.
// Output register plus one skid entry: input stalls only while the skid entry is full.
// Reset (rst, synchronous): line start, no data/type/id/retry state, outputs empty.
module sse_stream_tokenizer #(
  parameter int RETRY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [7:0]  token_byte,
  output logic [31:0] retry_ms,
  output logic        default_type
);

  logic [2:0] phase, phase_next;
  logic [2:0] nlen, nlen_next;
  logic [3:0] cand, cand_next;
  logic [2:0] fkind, fkind_next;
  logic swallow, swallow_next;
  logic has_data, has_data_next;
  logic type_ne, type_ne_next;
  logic id_nul, id_nul_next;
  logic [RETRY_BITS-1:0] racc, racc_next;
  logic rgood, rgood_next;

  logic ov, sv;
  sst_pkg::tok_t out_tok, skid_tok, res;
  logic res_valid;

  logic accept;
  logic [2:0] open_kind;
  logic [RETRY_BITS+31:0] racc_wide;
  logic [RETRY_BITS-1:0] ra;
  logic rg;
  logic [RETRY_BITS+3:0] prod;
  logic is_digit, first, do_end;

  assign in_ready = !sv;
  assign accept = in_valid && in_ready;
  assign racc_wide = {32'b0, racc};
  assign is_digit = (in_byte >= sst_pkg::CH_ZERO) && (in_byte <= sst_pkg::CH_NINE);
  assign first = (phase == sst_pkg::PH_COLON) || (phase == sst_pkg::PH_FIRST);
  assign ra = first ? '0 : racc;
  assign rg = first ? 1'b1 : rgood;
  assign prod = ({4'b0, ra} << 3) + ({4'b0, ra} << 1)
              + {{(RETRY_BITS){1'b0}}, in_byte[3:0] - sst_pkg::CH_ZERO[3:0]};

  always_comb begin
    open_kind = sst_pkg::FK_UNKNOWN;
    for (int i = 3; i >= 0; i--) begin
      if (cand[i] && nlen == sst_pkg::name_len(2'(i))) open_kind = 3'(i + 1);
    end
  end

  always_comb begin
    phase_next    = phase;
    nlen_next     = nlen;
    cand_next     = cand;
    fkind_next    = fkind;
    swallow_next  = swallow;
    has_data_next = has_data;
    type_ne_next  = type_ne;
    id_nul_next   = id_nul;
    racc_next     = racc;
    rgood_next    = rgood;
    res_valid     = 1'b0;
    res           = '0;
    do_end        = 1'b0;
    if (accept) begin
      swallow_next = 1'b0;
      if (req_type) begin
        do_end = (phase != sst_pkg::PH_START);
      end else if (swallow && in_byte == sst_pkg::CH_LF) begin
        do_end = 1'b0;
      end else if (in_byte == sst_pkg::CH_CR || in_byte == sst_pkg::CH_LF) begin
        do_end = 1'b1;
        swallow_next = (in_byte == sst_pkg::CH_CR);
      end else begin
        case (phase)
          sst_pkg::PH_START, sst_pkg::PH_NAME: begin
            if (phase == sst_pkg::PH_START && in_byte == sst_pkg::CH_COLON) begin
              phase_next = sst_pkg::PH_COMMENT;
            end else if (in_byte == sst_pkg::CH_COLON) begin
              phase_next = sst_pkg::PH_COLON;
              fkind_next = open_kind;
              case (open_kind)
                sst_pkg::FK_DATA: begin
                  res_valid = has_data;
                  res.kind = sst_pkg::TK_DATA_BYTE;
                  res.data_byte = sst_pkg::CH_LF;
                  has_data_next = 1'b1;
                end
                sst_pkg::FK_EVENT: begin
                  type_ne_next = 1'b0;
                  res_valid = 1'b1;
                  res.kind = sst_pkg::TK_TYPE_START;
                end
                sst_pkg::FK_ID: id_nul_next = 1'b0;
                sst_pkg::FK_RETRY: begin
                  racc_next = '0;
                  rgood_next = 1'b0;
                end
                default: ;
              endcase
            end else begin
              phase_next = sst_pkg::PH_NAME;
              for (int i = 0; i < 4; i++) begin
                cand_next[i] = (phase == sst_pkg::PH_START || cand[i])
                  && ((phase == sst_pkg::PH_START ? 3'd0 : nlen) < sst_pkg::name_len(2'(i)))
                  && (sst_pkg::name_char(2'(i), phase == sst_pkg::PH_START ? 3'd0 : nlen)
                      == in_byte);
              end
              if (phase == sst_pkg::PH_START) nlen_next = 3'd1;
              else if (nlen != 3'd7) nlen_next = nlen + 3'd1;
            end
          end
          sst_pkg::PH_COLON, sst_pkg::PH_FIRST, sst_pkg::PH_VALUE: begin
            phase_next = sst_pkg::PH_VALUE;
            if (phase == sst_pkg::PH_COLON && in_byte == sst_pkg::CH_SPACE) begin
              phase_next = sst_pkg::PH_FIRST;
            end else begin
              res.data_byte = in_byte;
              case (fkind)
                sst_pkg::FK_DATA: begin
                  res_valid = 1'b1;
                  res.kind = sst_pkg::TK_DATA_BYTE;
                end
                sst_pkg::FK_EVENT: begin
                  type_ne_next = 1'b1;
                  res_valid = 1'b1;
                  res.kind = sst_pkg::TK_TYPE_BYTE;
                end
                sst_pkg::FK_ID: begin
                  if (in_byte == sst_pkg::CH_NUL) id_nul_next = 1'b1;
                  res_valid = 1'b1;
                  res.kind = sst_pkg::TK_ID_BYTE;
                end
                sst_pkg::FK_RETRY: begin
                  racc_next = ra;
                  rgood_next = rg;
                  if (!is_digit) begin
                    rgood_next = 1'b0;
                  end else if (rg) begin
                    if (|prod[RETRY_BITS+3:RETRY_BITS]) rgood_next = 1'b0;
                    else racc_next = prod[RETRY_BITS-1:0];
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
    end

    if (do_end) begin
      case (phase)
        sst_pkg::PH_START: begin
          res_valid = 1'b1;
          res.kind = has_data ? sst_pkg::TK_DISPATCH : sst_pkg::TK_DISCARD;
          res.dflt = has_data && !type_ne;
          has_data_next = 1'b0;
          type_ne_next = 1'b0;
          racc_next = '0;
          rgood_next = 1'b0;
        end
        sst_pkg::PH_NAME: begin
          case (open_kind)
            sst_pkg::FK_DATA: begin
              res_valid = has_data;
              res.kind = sst_pkg::TK_DATA_BYTE;
              res.data_byte = sst_pkg::CH_LF;
              has_data_next = 1'b1;
            end
            sst_pkg::FK_EVENT: begin
              type_ne_next = 1'b0;
              res_valid = 1'b1;
              res.kind = sst_pkg::TK_TYPE_START;
            end
            sst_pkg::FK_ID: begin
              id_nul_next = 1'b0;
              res_valid = 1'b1;
              res.kind = sst_pkg::TK_ID_COMMIT;
            end
            sst_pkg::FK_RETRY: begin
              racc_next = '0;
              rgood_next = 1'b0;
              res_valid = 1'b1;
              res.kind = sst_pkg::TK_RETRY_CLEAR;
            end
            default: ;
          endcase
        end
        sst_pkg::PH_COLON, sst_pkg::PH_FIRST, sst_pkg::PH_VALUE: begin
          if (fkind == sst_pkg::FK_ID) begin
            res_valid = 1'b1;
            res.kind = id_nul ? sst_pkg::TK_ID_REJECT : sst_pkg::TK_ID_COMMIT;
          end else if (fkind == sst_pkg::FK_RETRY) begin
            res_valid = 1'b1;
            res.kind = rgood ? sst_pkg::TK_RETRY_SET : sst_pkg::TK_RETRY_CLEAR;
            res.ms = rgood ? racc_wide[31:0] : 32'd0;
          end
        end
        default: ;
      endcase
      phase_next = sst_pkg::PH_START;
      nlen_next  = 3'd0;
      cand_next  = sst_pkg::CAND_ALL;
      fkind_next = sst_pkg::FK_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= sst_pkg::PH_START;
      nlen     <= 3'd0;
      cand     <= sst_pkg::CAND_ALL;
      fkind    <= sst_pkg::FK_UNKNOWN;
      swallow  <= 1'b0;
      has_data <= 1'b0;
      type_ne  <= 1'b0;
      id_nul   <= 1'b0;
      racc     <= '0;
      rgood    <= 1'b0;
    end else begin
      phase    <= phase_next;
      nlen     <= nlen_next;
      cand     <= cand_next;
      fkind    <= fkind_next;
      swallow  <= swallow_next;
      has_data <= has_data_next;
      type_ne  <= type_ne_next;
      id_nul   <= id_nul_next;
      racc     <= racc_next;
      rgood    <= rgood_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (out_ready) begin
        sv <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!ov || out_ready) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end else if (out_ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (out_ready) out_tok <= skid_tok;
    end else if (accept && res_valid) begin
      if (!ov || out_ready) out_tok <= res;
      else skid_tok <= res;
    end
  end

  assign out_valid    = ov;
  assign token_kind   = out_tok.kind;
  assign token_byte   = out_tok.data_byte;
  assign retry_ms     = out_tok.ms;
  assign default_type = out_tok.dflt;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry held without output entry");
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    phase == sst_pkg::PH_START |-> nlen == 3'd0 && cand == sst_pkg::CAND_ALL
      && fkind == sst_pkg::FK_UNKNOWN)
    else $error("line start with stale name state");
  a_no_field_in_name: assert property (@(posedge clk) disable iff (rst)
    (phase == sst_pkg::PH_NAME || phase == sst_pkg::PH_COMMENT)
      |-> fkind == sst_pkg::FK_UNKNOWN)
    else $error("field kind set before name settled");
  a_dflt_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    ov && token_kind != sst_pkg::TK_DISPATCH |-> !default_type)
    else $error("default type flag on non-dispatch token");
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    sv && !out_ready |=> sv && $stable(skid_tok))
    else $error("skid entry lost while output stalled");

endmodule
